FILE: src/cf32_pkg.sv
// shared types, opcodes and helpers for the custom float32 arithmetic unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cf32_pkg;

    localparam int WordW     = 32;
    localparam int FracW     = 24;
    localparam int Bias      = 64;
    localparam int ExpW      = 10;
    localparam int DivSteps  = 4;
    localparam int DivStages = FracW / DivSteps;

    localparam logic [WordW-1:0] MagMax  = 32'h7FFF_FFFF;
    localparam logic [WordW-1:0] SignBit = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CMP  = 3'd4,
        OP_NEG  = 3'd5,
        OP_ITOF = 3'd6,
        OP_FTOI = 3'd7
    } op_t;

    // one item in flight
    typedef struct packed {
        logic                     bypass;
        logic                     sign;
        logic signed [ExpW-1:0]   expo;
        logic [WordW-1:0]         frac;
        logic [WordW-1:0]         word;
        logic                     ovf;
        logic                     is_div;
        logic [FracW-1:0]         rem;
        logic [FracW-1:0]         dvs;
        logic [FracW-1:0]         quo;
    } work_t;

    // unbiased exponent of a float word
    function automatic logic signed [ExpW-1:0] unb_exp(input logic [WordW-1:0] w);
        unb_exp = $signed({3'b000, w[30:24]}) - $signed(ExpW'(Bias));
    endfunction

endpackage
`default_nettype wire

FILE: src/cf32_if.sv
// valid/ready channel interfaces for operations and results
// depends on cf32_pkg
`timescale 1ns / 1ps
`default_nettype none
interface cf32_in_if;
    logic               valid;
    logic               ready;
    cf32_pkg::op_t      op;
    logic [31:0]        operand_a;
    logic [31:0]        operand_b;
    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface cf32_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        result;
    logic               overflow;
    logic               underflow;
    modport source (output valid, result, overflow, underflow, input ready);
    modport sink (input valid, result, overflow, underflow, output ready);
endinterface
`default_nettype wire

FILE: src/cf32_div_stage.sv
// one pipeline slice of the restoring divider: four quotient bits per stage
// depends on cf32_pkg
`timescale 1ns / 1ps
`default_nettype none
module cf32_div_stage #(
    parameter int StageIdx = 0
) (
    input  cf32_pkg::work_t din,
    output cf32_pkg::work_t dout
);

    // restoring steps, divisor halves after each
    always_comb
    begin
        dout = din;
        for (int j = 0; j < cf32_pkg::DivSteps; j++)
        begin
            if (dout.rem >= dout.dvs)
            begin
                dout.quo[cf32_pkg::FracW-1-(StageIdx*cf32_pkg::DivSteps+j)] = 1'b1;
                dout.rem = dout.rem - dout.dvs;
            end
            dout.dvs = dout.dvs >> 1;
        end
    end

endmodule
`default_nettype wire

FILE: src/custom_float32_arith_unit.sv
// top level of the custom float32 arithmetic unit
// depends on cf32_pkg, cf32_if and cf32_div_stage
`timescale 1ns / 1ps
`default_nettype none
// Pipelined arithmetic unit for the excess-64 float word (sign bit 31, exponent
// bits 30..24, 24-bit fraction with explicit leading one). It takes one operation
// every cycle while the output side does not stall. The depth is a register behind
// the decode, align and multiply logic, then the divider, which resolves four
// quotient bits in each of six stages, followed by a rounding stage, a normalizing
// shift stage and the packing output register. Every operation runs the same path,
// so results leave in order. Each stage holds while the next one is full, so a
// stalled output fills the pipe and the input keeps taking transfers until it is
// full.
module custom_float32_arith_unit (
    input  wire        clk,
    input  wire        rst_n,
    cf32_in_if.sink    in_ch,
    cf32_out_if.source out_ch
);

    localparam int NStg = cf32_pkg::DivStages + 3;
    localparam int RndS = cf32_pkg::DivStages + 1;
    localparam int LzS  = cf32_pkg::DivStages + 2;

    logic [NStg-1:0]  vld_reg;
    logic [NStg-1:0]  free;
    cf32_pkg::work_t  stg_reg  [NStg];
    cf32_pkg::work_t  stg_next [NStg];
    logic             out_vld_reg;
    logic             out_free;
    logic [31:0]      res_reg, res_next;
    logic             ovf_reg, ovf_next;
    logic             unf_reg, unf_next;

    // front end: decode, align and add, multiply, conversions
    always_comb
    begin
        logic [31:0]        a, bb, mag, fi;
        logic signed [9:0]  eu, ev, ef;
        logic signed [7:0]  t;
        logic [6:0]         amt;
        logic signed [25:0] fu, fv, big, lesser, fw;
        cf32_pkg::work_t    w;
        a  = in_ch.operand_a;
        bb = (in_ch.op == cf32_pkg::OP_SUB) ? (in_ch.operand_b ^ cf32_pkg::SignBit)
                                            : in_ch.operand_b;
        eu = cf32_pkg::unb_exp(a);
        ev = cf32_pkg::unb_exp(bb);
        w  = '0;
        fu = a[31]  ? -$signed({2'b00, a[23:0]})  : $signed({2'b00, a[23:0]});
        fv = bb[31] ? -$signed({2'b00, bb[23:0]}) : $signed({2'b00, bb[23:0]});
        t  = $signed({1'b0, a[30:24]}) - $signed({1'b0, bb[30:24]});
        amt = t[7] ? 7'(-t) : t[6:0];
        big    = (t <= 0) ? fv : fu;
        lesser = (t <= 0) ? fu : fv;
        fw = (amt >= 7'd24) ? big : big + (lesser >>> amt[4:0]);
        mag = '0;
        fi  = {8'h00, a[23:0]};
        ef  = eu;
        case (in_ch.op)
            cf32_pkg::OP_ADD, cf32_pkg::OP_SUB:
            begin
                if (a == '0)
                begin
                    w.bypass = 1'b1;
                    w.word   = bb;
                end
                else if (bb == '0)
                begin
                    w.bypass = 1'b1;
                    w.word   = a;
                end
                else
                begin
                    w.sign = fw[25];
                    w.frac = {6'b0, fw[25] ? 26'(-fw) : 26'(fw)};
                    w.expo = (t <= 0) ? ev : eu;
                end
            end
            cf32_pkg::OP_MUL:
            begin
                if (a[23:0] == '0 || bb[23:0] == '0)
                begin
                    w.bypass = 1'b1;
                end
                else
                begin
                    w.sign = a[31] ^ bb[31];
                    w.frac = a[23:8] * bb[23:8];
                    w.expo = eu + ev - 10'sd8;
                end
            end
            cf32_pkg::OP_DIV:
            begin
                if (a[23:0] == '0 || bb[23:0] == '0)
                begin
                    w.bypass = 1'b1;
                end
                else
                begin
                    w.is_div = 1'b1;
                    w.sign   = a[31] ^ bb[31];
                    w.rem    = a[23:0];
                    w.dvs    = bb[23:0];
                    w.expo   = eu - ev + 10'sd1;
                end
            end
            cf32_pkg::OP_CMP:
            begin
                w.bypass = 1'b1;
                w.word   = (a[31] && bb[31]) ? (bb - a) : (a - bb);
            end
            cf32_pkg::OP_NEG:
            begin
                w.bypass = 1'b1;
                w.word   = a ^ cf32_pkg::SignBit;
            end
            cf32_pkg::OP_ITOF:
            begin
                w.sign = a[31];
                w.frac = a[31] ? (32'd0 - a) : a;
                w.expo = 10'sd24;
            end
            default:
            begin
                // float to int, truncating toward zero
                w.bypass = 1'b1;
                if (ef <= 0)
                    mag = '0;
                else if (ef < 10'sd24)
                    mag = fi >> 5'(10'sd24 - ef);
                else if (ef == 10'sd24)
                    mag = fi;
                else if (ef < 10'sd32)
                    mag = fi << 3'(ef - 10'sd24);
                else
                begin
                    mag   = cf32_pkg::MagMax;
                    w.ovf = 1'b1;
                end
                w.word = a[31] ? (32'd0 - mag) : mag;
            end
        endcase
        stg_next[0] = w;
    end

    // divider slices
    for (genvar k = 0; k < cf32_pkg::DivStages; k++)
    begin : g_div
        cf32_div_stage #(.StageIdx(k)) u_div (
            .din  (stg_reg[k]),
            .dout (stg_next[k+1])
        );
    end

    // right normalize: repeated half-up steps equal one ceiling division by 2^sh,
    // with one more step when the rounding carries into bit 24
    always_comb
    begin
        cf32_pkg::work_t w;
        logic [3:0]      sh;
        logic [31:0]     q;
        logic            rb;
        w = stg_reg[RndS-1];
        if (w.is_div)
            w.frac = {8'h00, w.quo};
        sh = '0;
        for (int i = 24; i < 32; i++)
        begin
            if (w.frac[i])
                sh = 4'(i - 23);
        end
        q  = w.frac >> sh;
        rb = |(w.frac & ~({32{1'b1}} << sh));
        q  = q + {31'b0, rb};
        if (q[24])
        begin
            q  = 32'h0080_0000;
            sh = sh + 4'd1;
        end
        w.frac = q;
        w.expo = w.expo + $signed({6'b0, sh});
        stg_next[RndS] = w;
    end

    // left normalize to the explicit leading one
    always_comb
    begin
        cf32_pkg::work_t w;
        logic [4:0]      lz;
        w  = stg_reg[RndS];
        lz = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (w.frac[i])
                lz = 5'(23 - i);
        end
        if (w.frac[23:0] != '0)
        begin
            w.frac = w.frac << lz;
            w.expo = w.expo - $signed({5'b0, lz});
        end
        stg_next[LzS] = w;
    end

    // range check and packing
    always_comb
    begin
        cf32_pkg::work_t w;
        logic [6:0]      be;
        w        = stg_reg[LzS];
        be       = 7'(w.expo + 10'sd64);
        res_next = '0;
        ovf_next = 1'b0;
        unf_next = 1'b0;
        if (w.bypass)
        begin
            res_next = w.word;
            ovf_next = w.ovf;
        end
        else if (w.frac == '0)
            res_next = '0;
        else if (w.expo >= 10'sd64)
        begin
            res_next = {w.sign, cf32_pkg::MagMax[30:0]};
            ovf_next = 1'b1;
        end
        else if (w.expo < -10'sd64)
            unf_next = 1'b1;
        else
            res_next = {w.sign, be, w.frac[23:0]};
    end

    // stall chain: a stage takes new data when it is empty or moves on
    assign out_free = !out_vld_reg || out_ch.ready;
    always_comb
    begin
        free[NStg-1] = !vld_reg[NStg-1] || out_free;
        for (int i = NStg - 2; i >= 0; i--)
            free[i] = !vld_reg[i] || free[i+1];
    end
    assign in_ch.ready = free[0];

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (free[0])
                vld_reg[0] <= in_ch.valid;
            for (int i = 1; i < NStg; i++)
            begin
                if (free[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
            if (out_free)
                out_vld_reg <= vld_reg[NStg-1];
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (free[0] && in_ch.valid)
            stg_reg[0] <= stg_next[0];
        for (int i = 1; i < NStg; i++)
        begin
            if (free[i] && vld_reg[i-1])
                stg_reg[i] <= stg_next[i];
        end
        if (out_free && vld_reg[NStg-1])
        begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
            unf_reg <= unf_next;
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.result    = res_reg;
    assign out_ch.overflow  = ovf_reg;
    assign out_ch.underflow = unf_reg;

endmodule
`default_nettype wire

FILE: test/tb_custom_float32_arith_unit.sv
// self-checking testbench for the custom float32 arithmetic unit
// depends on cf32_pkg, cf32_if and the unit's rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_custom_float32_arith_unit;

    localparam int RandItems = 950;
    localparam int Watchdog  = 5000;
    localparam int Latency   = 10;

    typedef struct {
        logic [31:0] result;
        logic        overflow;
        logic        underflow;
    } fres_t;

    typedef struct {
        cf32_pkg::op_t op;
        logic [31:0]   a;
        logic [31:0]   b;
        logic          typed;
        logic [31:0]   result;
        logic          overflow;
        logic          underflow;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cf32_in_if  in_ch ();
    cf32_out_if out_ch ();

    custom_float32_arith_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #5 clk = ~clk;

    fres_t       pending_q[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          timed_out = 0;
    bit          quiet = 0;
    bit          hold_rx = 0;
    bit          stim_done = 0;
    vec_t        stim_q[$];

    // normalize and pack a sign, exponent and magnitude
    function automatic fres_t pack_word(logic s, int e, logic [31:0] f);
        fres_t r;
        r.result = '0;
        r.overflow = 1'b0;
        r.underflow = 1'b0;
        if (f == 0) return r;
        while (f[31:24] != 0)
        begin
            f = (f >> 1) + f[0];
            e++;
        end
        while (!f[23])
        begin
            f = f << 1;
            e--;
        end
        if (e >= 64)
        begin
            r.overflow = 1'b1;
            r.result = {s, 31'h7FFF_FFFF};
        end
        else if (e < -64)
        begin
            r.underflow = 1'b1;
        end
        else
        begin
            r.result = {s, 7'(e + 64), f[23:0]};
        end
        return r;
    endfunction

    function automatic int exp_of(logic [31:0] w);
        return int'(w[30:24]) - 64;
    endfunction

    // arithmetic shift right toward minus infinity
    function automatic longint shr_floor(longint x, int k);
        if (x >= 0) return x >>> k;
        return -(((-x) - 1) >>> k) - 1;
    endfunction

    function automatic fres_t float_sum(logic [31:0] u, logic [31:0] v);
        fres_t  r;
        int     eu, ev, ew, t;
        longint fu, fv, fw;
        logic   sw;
        r.overflow = 1'b0;
        r.underflow = 1'b0;
        if (u == 0)
        begin
            r.result = v;
            return r;
        end
        if (v == 0)
        begin
            r.result = u;
            return r;
        end
        eu = exp_of(u);
        ev = exp_of(v);
        fu = longint'(u[23:0]);
        fv = longint'(v[23:0]);
        if (u[31]) fu = -fu;
        if (v[31]) fv = -fv;
        t = eu - ev;
        if (t <= -24)
        begin
            fw = fv; ew = ev;
        end
        else if (t <= 0)
        begin
            fw = fv + shr_floor(fu, -t); ew = ev;
        end
        else if (t < 24)
        begin
            fw = fu + shr_floor(fv, t); ew = eu;
        end
        else
        begin
            fw = fu; ew = eu;
        end
        sw = (fw < 0);
        if (fw < 0) fw = -fw;
        return pack_word(sw, ew, 32'(fw));
    endfunction

    function automatic fres_t float_quotient(logic [31:0] u, logic [31:0] v);
        fres_t       r;
        logic [31:0] fu, fv, fw;
        fu = u[23:0];
        fv = v[23:0];
        fw = 0;
        r = '{32'h0, 1'b0, 1'b0};
        if (fu == 0 || fv == 0) return r;
        for (int i = 23; i >= 0; i--)
        begin
            if (fu >= fv)
            begin
                fw += 32'(1) << i;
                fu -= fv;
            end
            fv >>= 1;
        end
        return pack_word(u[31] ^ v[31], exp_of(u) - exp_of(v) + 1, fw);
    endfunction

    function automatic fres_t float_to_int(logic [31:0] u);
        fres_t       r;
        int          e;
        logic [31:0] f;
        e = exp_of(u);
        f = u[23:0];
        r = '{32'h0, 1'b0, 1'b0};
        if (e <= 0) return r;
        if (e < 24) f = f >> (24 - e);
        else if (e > 24 && e < 32) f = f << (e - 24);
        else if (e >= 32)
        begin
            r.overflow = 1'b1;
            f = 32'h7FFF_FFFF;
        end
        r.result = u[31] ? (32'h0 - f) : f;
        return r;
    endfunction

    function automatic fres_t predict_unit(cf32_pkg::op_t op, logic [31:0] a,
                                           logic [31:0] b);
        fres_t r;
        r = '{32'h0, 1'b0, 1'b0};
        case (op)
            cf32_pkg::OP_ADD:  r = float_sum(a, b);
            cf32_pkg::OP_SUB:  r = float_sum(a, b ^ cf32_pkg::SignBit);
            cf32_pkg::OP_MUL:
                if (a[23:0] != 0 && b[23:0] != 0)
                    r = pack_word(a[31] ^ b[31], exp_of(a) + exp_of(b) - 8,
                                  {16'h0, a[23:8]} * {16'h0, b[23:8]});
            cf32_pkg::OP_DIV:  r = float_quotient(a, b);
            cf32_pkg::OP_CMP:  r.result = (a[31] && b[31]) ? (b - a) : (a - b);
            cf32_pkg::OP_NEG:  r.result = a ^ cf32_pkg::SignBit;
            cf32_pkg::OP_ITOF: r = pack_word(a[31], 24, a[31] ? (32'h0 - a) : a);
            default: r = float_to_int(a);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: w[30:24] = 7'($urandom_range(60, 70));
            1: w[30:24] = $urandom_range(0, 1) ? 7'h7F : 7'h00;
            2: w[23:0] = 24'h0;
            3: w[23] = 1'b0;
            default: w[23] = 1'b1;
        endcase
        return w;
    endfunction

    // directed rows, typed expectations where obvious
    initial
    begin
        vec_t v;
        stim_q.push_back('{cf32_pkg::OP_ADD, 32'h0, 32'hDEAD_BEEF, 1, 32'hDEAD_BEEF, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_ADD, 32'h4180_0000, 32'h0, 1, 32'h4180_0000, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                           32'h7FFF_FFFF, 1, 0});
        stim_q.push_back('{cf32_pkg::OP_ADD, 32'h4180_0000, 32'h5A80_0000, 0, 0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_ADD, 32'hC0FF_FFFF, 32'h40FF_FFFF, 1, 32'h0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_SUB, 32'h4180_0000, 32'h4180_0000, 1, 32'h0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_SUB, 32'h4180_0001, 32'hC2FF_FFFF, 0, 0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_MUL, 32'h4180_0000, 32'h0, 1, 32'h0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                           32'h7FFF_FFFF, 1, 0});
        stim_q.push_back('{cf32_pkg::OP_MUL, 32'h0080_0000, 32'h0080_0000, 1, 32'h0, 0, 1});
        stim_q.push_back('{cf32_pkg::OP_MUL, 32'hC1C0_0000, 32'h40FF_FFFF, 0, 0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_DIV, 32'h4180_0000, 32'h4100_0000, 1, 32'h0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0080_0000, 1,
                           32'h7FFF_FFFF, 1, 0});
        stim_q.push_back('{cf32_pkg::OP_DIV, 32'h0080_0000, 32'h7FFF_FFFF, 0, 0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_DIV, 32'hC100_0001, 32'h4000_0003, 0, 0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_CMP, 32'h8000_0001, 32'h8000_0005, 1, 32'h4, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_CMP, 32'h0, 32'hFFFF_FFFF, 1, 32'h1, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_NEG, 32'h1234_5678, 32'hFFFF_FFFF, 1,
                           32'h9234_5678, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_ITOF, 32'h8000_0000, 32'h0, 1, 32'hE080_0000, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_ITOF, 32'h0, 32'h0, 1, 32'h0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_ITOF, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_FTOI, 32'h40FF_FFFF, 32'h0, 1, 32'h0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_FTOI, 32'hE0FF_FFFF, 32'h0, 1, 32'h8000_0001, 1, 0});
        stim_q.push_back('{cf32_pkg::OP_FTOI, 32'hD7FF_FFFF, 32'h0, 0, 0, 0, 0});
        stim_q.push_back('{cf32_pkg::OP_FTOI, 32'h4AFF_FFFF, 32'h0, 0, 0, 0, 0});
        for (int i = 0; i < RandItems; i++)
        begin
            v.op = cf32_pkg::op_t'($urandom_range(0, 7));
            v.a = (v.op == cf32_pkg::OP_ITOF || v.op == cf32_pkg::OP_CMP) ?
                  32'($urandom) : rand_float();
            if (v.op == cf32_pkg::OP_FTOI && $urandom_range(0, 1))
                v.a[30:24] = 7'($urandom_range(60, 100));
            v.b = rand_float();
            v.typed = 0;
            stim_q.push_back(v);
        end
    end

    // reset and clock count
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.op = cf32_pkg::OP_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: drive one row per transfer, random idle bursts
    initial
    begin
        int   n;
        int   gap;
        vec_t v;
        fres_t e;
        @(posedge clk iff rst_n);
        n = 0;
        while (stim_q.size() > 0)
        begin
            gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            v = stim_q.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.op <= v.op;
            in_ch.operand_a <= v.a;
            in_ch.operand_b <= v.b;
            @(posedge clk iff in_ch.ready);
            if (v.typed) e = '{v.result, v.overflow, v.underflow};
            else e = predict_unit(v.op, v.a, v.b);
            pending_q.push_back(e);
            n++;
            if (n == 300) hold_rx = 1;
            if (stim_q.size() < 120) quiet = 1;
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int k;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_rx)
            begin
                hold_rx = 0;
                out_ch.ready <= 1'b0;
                for (k = 0; k < 60; k++) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // compare each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        fres_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_ch.result);
            end
            else
            begin
                e = pending_q.pop_front();
                if (out_ch.result !== e.result || out_ch.overflow !== e.overflow ||
                    out_ch.underflow !== e.underflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h ovf %b unf %b, got %h ovf %b unf %b",
                                 e.result, e.overflow, e.underflow,
                                 out_ch.result, out_ch.overflow, out_ch.underflow);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // end of run
    initial
    begin
        @(posedge clk iff rst_n);
        wait (stim_done && pending_q.size() == 0 || idle_cycles >= Watchdog);
        if (idle_cycles >= Watchdog)
        begin
            $display("custom_float32_arith_unit regression: fail");
            $finish;
        end
        else
        begin
            repeat (Latency * 3) @(posedge clk);
            if (mismatches == 0 && pending_q.size() == 0)
                $display("custom_float32_arith_unit regression: pass");
            else
                $display("custom_float32_arith_unit regression: fail");
            $finish;
        end
    end

endmodule
`default_nettype wire

FILE: filelist.f
src/cf32_pkg.sv
src/cf32_if.sv
src/cf32_div_stage.sv
src/custom_float32_arith_unit.sv
test/tb_custom_float32_arith_unit.sv
